>>> rtl/slcd_pkg.sv
// slcd_pkg: shared types and constants for the sync/length/checksum deframer.
// Used by slcd_parser, slcd_out_reg and sync_length_checksum_deframer.
// No dependencies.
package slcd_pkg;

   localparam logic [7:0]  SYNC_FIRST       = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND      = 8'h55;
   localparam logic [15:0] MIN_FRAME_LENGTH = 16'd6;
   localparam logic [15:0] HEADER_LENGTH    = 16'd5;
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd512;

   localparam logic [15:0] POS_SYNC1   = 16'd1;
   localparam logic [15:0] POS_SYNC2   = 16'd2;
   localparam logic [15:0] POS_LEN_HI  = 16'd3;
   localparam logic [15:0] POS_LEN_LO  = 16'd4;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_ACCEPT   = 2'd1,
      KIND_CSUM_ERR = 2'd2,
      KIND_LEN_ERR  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  frame_kind;
      logic [15:0] frame_length;
   } result_type;

endpackage

>>> rtl/slcd_parser.sv
// slcd_parser: frame parse state, running checksum and the max-length register.
// Produces at most one result per accepted byte, combinationally from the beat.
// Depends on slcd_pkg.
module slcd_parser
   import slcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        beat,
   input  logic [7:0]  rx_byte,
   input  logic        csr_write,
   input  logic [15:0] csr_data,
   output logic        res_valid,
   output result_type  res
);

   typedef enum logic [2:0] {
      PH_HUNT1  = 3'd0,
      PH_HUNT2  = 3'd1,
      PH_LEN_HI = 3'd2,
      PH_LEN_LO = 3'd3,
      PH_TYPE   = 3'd4,
      PH_BODY   = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] max_len_ff;

   logic [15:0] len_full;
   logic [16:0] pos_next;
   logic [7:0]  sum_add;

   assign len_full = {len_ff[15:8], rx_byte};
   assign pos_next = {1'b0, pos_ff} + 17'd1;
   assign sum_add  = sum_ff + rx_byte;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      type_in   = type_ff;
      res_valid = 1'b0;
      res       = '{kind: KIND_PAYLOAD, data_byte: 8'd0, frame_kind: type_ff,
                    frame_length: len_ff};
      case (phase_ff)
         PH_HUNT2: begin
            if (rx_byte == SYNC_SECOND) begin
               sum_in   = SYNC_FIRST + SYNC_SECOND;
               pos_in   = POS_SYNC2;
               phase_in = PH_LEN_HI;
            end else if (rx_byte != SYNC_FIRST) begin
               phase_in = PH_HUNT1;
               pos_in   = '0;
               sum_in   = '0;
            end
         end
         PH_LEN_HI: begin
            len_in   = {rx_byte, 8'd0};
            sum_in   = sum_add;
            pos_in   = POS_LEN_HI;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in = len_full;
            if (len_full < MIN_FRAME_LENGTH || len_full > max_len_ff) begin
               phase_in  = PH_HUNT1;
               pos_in    = '0;
               sum_in    = '0;
               res_valid = 1'b1;
               res       = '{kind: KIND_LEN_ERR, data_byte: 8'd0, frame_kind: 8'd0,
                             frame_length: len_full};
            end else begin
               sum_in   = sum_add;
               pos_in   = POS_LEN_LO;
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            type_in  = rx_byte;
            sum_in   = sum_add;
            pos_in   = HEADER_LENGTH;
            phase_in = PH_BODY;
         end
         PH_BODY: begin
            res_valid = 1'b1;
            if (pos_next >= {1'b0, len_ff}) begin
               phase_in = PH_HUNT1;
               pos_in   = '0;
               sum_in   = '0;
               res.kind = (rx_byte == sum_ff) ? KIND_ACCEPT : KIND_CSUM_ERR;
            end else begin
               sum_in        = sum_add;
               pos_in        = pos_next[15:0];
               res.data_byte = rx_byte;
            end
         end
         default: begin
            if (rx_byte == SYNC_FIRST) begin
               phase_in = PH_HUNT2;
               pos_in   = POS_SYNC1;
            end else begin
               phase_in = PH_HUNT1;
               pos_in   = '0;
               sum_in   = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT1;
         pos_ff     <= '0;
         len_ff     <= '0;
         sum_ff     <= '0;
         type_ff    <= '0;
         max_len_ff <= MAX_LENGTH_RESET;
      end else begin
         if (beat) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            len_ff   <= len_in;
            sum_ff   <= sum_in;
            type_ff  <= type_in;
         end
         if (csr_write) begin
            max_len_ff <= csr_data;
         end
      end
   end

endmodule

>>> rtl/slcd_out_reg.sv
// slcd_out_reg: result register between the parser and the rsp channel.
// Reloads in the same cycle its beat is taken, so one result per cycle flows unless rsp stalls.
// Depends on slcd_pkg.
module slcd_out_reg
   import slcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       rsp_ready,
   output logic       can_load,
   output logic       rsp_valid,
   output result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign can_load  = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

>>> rtl/sync_length_checksum_deframer.sv
// sync_length_checksum_deframer: byte-serial frame parser, top level.
// Depends on slcd_pkg, slcd_parser and slcd_out_reg.
//
// req channel: one received byte per beat (req_rx_byte).
// rsp channel: zero or one result per byte: a payload byte tagged with frame
//   type and length, or a final accept / checksum error / length error.
// csr channel: writes max_frame_length (reset value 512); always ready.
//   Write it only while no results are outstanding.
// Frames: 0xAA 0x55, 16-bit big-endian total length, type byte, payload,
//   checksum byte equal to the 8-bit sum of all earlier frame bytes.
// Output: a result is registered and shows on rsp the cycle after its byte is accepted.
// Throughput: one byte per cycle while rsp is not stalled; the parse state updates
//   on each beat and the one-entry result register reloads while its beat is taken.
// Stall: while rsp_valid is high and rsp_ready low, req_ready is low.
// Reset: synchronous; parser returns to hunting for 0xAA, result register
//   empties, max_frame_length returns to 512.
module sync_length_checksum_deframer
   import slcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_frame_kind,
   output logic [15:0] rsp_frame_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_frame_length
);

   logic       beat;
   logic       can_load;
   logic       res_valid;
   result_type res;
   result_type rsp_data;

   assign csr_ready = 1'b1;
   assign req_ready = can_load;
   assign beat      = req_valid && can_load;

   slcd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .rx_byte   (req_rx_byte),
      .csr_write (csr_valid),
      .csr_data  (csr_max_frame_length),
      .res_valid (res_valid),
      .res       (res)
   );

   slcd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (beat && res_valid),
      .load_data (res),
      .rsp_ready (rsp_ready),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_result_kind  = rsp_data.kind;
   assign rsp_data_byte    = rsp_data.data_byte;
   assign rsp_frame_kind   = rsp_data.frame_kind;
   assign rsp_frame_length = rsp_data.frame_length;

endmodule

>>> verif/tb.sv
// tb: self-checking testbench for sync_length_checksum_deframer.
// Depends on slcd_pkg and the deframer RTL; a built-in parser model predicts
// every rsp beat, and a monitor compares beats as they are taken.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import slcd_pkg::*;

   localparam int unsigned ITEM_TARGET    = 1350;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned PRINT_LIMIT    = 40;

   typedef enum logic [2:0] {
      HUNT_FIRST, HUNT_SECOND, LEN_HIGH, LEN_LOW, TYPE_BYTE, BODY
   } hunt_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_frame_kind;
   logic [15:0] rsp_frame_length;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_max_frame_length = 16'h0000;

   // parser model state
   hunt_phase_type phase        = HUNT_FIRST;
   logic [15:0]    frame_pos    = '0;
   logic [15:0]    frame_len    = '0;
   logic [7:0]     frame_sum    = '0;
   logic [7:0]     frame_type   = '0;
   logic [15:0]    pred_max_len = MAX_LENGTH_RESET;
   result_type     parse_results[$];

   // stimulus side
   logic [15:0]    cfg_max_len   = MAX_LENGTH_RESET;
   bit             tx_idle       = 1'b0;
   bit             rx_idle       = 1'b0;
   bit             long_hold_req = 1'b0;
   int unsigned    bytes_sent    = 0;
   int unsigned    mismatch_count = 0;
   int unsigned    idle_cycles   = 0;

   sync_length_checksum_deframer u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_frame_kind       (rsp_frame_kind),
      .rsp_frame_length     (rsp_frame_length),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_frame_length (csr_max_frame_length)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void restart_hunt();
      phase     = HUNT_FIRST;
      frame_pos = '0;
      frame_sum = '0;
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      case (phase)
         HUNT_SECOND: begin
            if (b == SYNC_SECOND) begin
               frame_sum = SYNC_FIRST + SYNC_SECOND;
               frame_pos = POS_SYNC2;
               phase     = LEN_HIGH;
            end else if (b != SYNC_FIRST) begin
               restart_hunt();
            end
         end
         LEN_HIGH: begin
            frame_len = {b, 8'h00};
            frame_sum = frame_sum + b;
            frame_pos = POS_LEN_HI;
            phase     = LEN_LOW;
         end
         LEN_LOW: begin
            frame_len[7:0] = b;
            frame_sum = frame_sum + b;
            frame_pos = POS_LEN_LO;
            if (frame_len < MIN_FRAME_LENGTH || frame_len > pred_max_len) begin
               restart_hunt();
               r.kind         = KIND_LEN_ERR;
               r.frame_length = frame_len;
               parse_results.push_back(r);
            end else begin
               phase = TYPE_BYTE;
            end
         end
         TYPE_BYTE: begin
            frame_type = b;
            frame_sum  = frame_sum + b;
            frame_pos  = HEADER_LENGTH;
            phase      = BODY;
         end
         BODY: begin
            r.frame_kind   = frame_type;
            r.frame_length = frame_len;
            if ({1'b0, frame_pos} + 17'd1 >= {1'b0, frame_len}) begin
               r.kind = (b == frame_sum) ? KIND_ACCEPT : KIND_CSUM_ERR;
               restart_hunt();
            end else begin
               r.kind    = KIND_PAYLOAD;
               r.data_byte = b;
               frame_sum = frame_sum + b;
               frame_pos = frame_pos + 16'd1;
            end
            parse_results.push_back(r);
         end
         default: begin
            if (b == SYNC_FIRST) begin
               phase     = HUNT_SECOND;
               frame_pos = POS_SYNC1;
            end else begin
               restart_hunt();
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // checks taken rsp beats, tracks req/csr beats, watches for a hang
   always @(posedge clock) begin : monitor
      result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (parse_results.size() == 0) begin
               report_mismatch("unexpected result, kind", rsp_result_kind, 0);
            end else begin
               want = parse_results.pop_front();
               if (rsp_result_kind !== want.kind)
                  report_mismatch("result_kind", rsp_result_kind, want.kind);
               if (rsp_data_byte !== want.data_byte)
                  report_mismatch("data_byte", rsp_data_byte, want.data_byte);
               if (rsp_frame_kind !== want.frame_kind)
                  report_mismatch("frame_kind", rsp_frame_kind, want.frame_kind);
               if (rsp_frame_length !== want.frame_length)
                  report_mismatch("frame_length", rsp_frame_length, want.frame_length);
            end
         end
         if (req_valid && req_ready)
            parse_byte(req_rx_byte);
         if (csr_valid && csr_ready)
            pred_max_len = csr_max_frame_length;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("Some tests failed");
               $finish;
            end
         end
      end
   end

   function automatic int unsigned idle_gap();
      if ($urandom_range(0, 15) == 0)
         return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // rsp side: random stalls, plus one long hold on request
   initial begin : sink
      int unsigned hold;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = LONG_HOLD;
         end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            hold = idle_gap();
         end else begin
            hold = 0;
         end
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         gap = idle_gap();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // one frame with random payload; stops after the length field when the length is
   // below the minimum or above the current limit
   task automatic send_frame(input logic [15:0] len, input logic [7:0] ftype,
                             input bit corrupt);
      logic [7:0]  sum;
      logic [7:0]  b;
      int unsigned i;
      sum = SYNC_FIRST + SYNC_SECOND + len[15:8] + len[7:0];
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      if (len < MIN_FRAME_LENGTH || len > cfg_max_len)
         return;
      send_byte(ftype);
      sum = sum + ftype;
      for (i = MIN_FRAME_LENGTH; i < len; i++) begin
         b = 8'($urandom);
         send_byte(b);
         sum = sum + b;
      end
      send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (parse_results.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_max_len(input logic [15:0] value);
      drain_results();
      cfg_max_len          = value;
      csr_valid            <= 1'b1;
      csr_max_frame_length <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed();
      logic [7:0] seq[$];
      seq = '{8'h00, 8'hFF,
              8'hAA, 8'hAA, 8'h55, 8'h00, 8'h07, 8'h01, 8'hFF, 8'h06,
              8'hAA, 8'h12,
              8'hAA, 8'h55, 8'h00, 8'h05,
              8'hAA, 8'h55, 8'hFF, 8'hFF,
              8'hAA, 8'h55, 8'h00, 8'h06, 8'hFE, 8'h5A};
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      foreach (seq[i])
         send_byte(seq[i]);
   endtask

   task automatic test_max_length();
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      set_max_len(16'd10);
      send_frame(16'd10, 8'h00, 1'b0);
      send_frame(16'd11, 8'h01, 1'b0);
      set_max_len(16'd6);
      send_frame(16'd6, 8'h01, 1'b0);
      send_frame(16'd7, 8'h00, 1'b0);
      set_max_len(16'd5);
      send_frame(16'd6, 8'h00, 1'b0);
      set_max_len(16'h0000);
      send_frame(16'd6, 8'h01, 1'b0);
      send_frame(16'd0, 8'h00, 1'b0);
      set_max_len(16'hFFFF);
      send_frame(16'd300, 8'h02, 1'b0);
      send_frame(16'd8, 8'h00, 1'b1);
      set_max_len(MAX_LENGTH_RESET);
      send_frame(MAX_LENGTH_RESET, 8'h00, 1'b0);
      send_frame(MAX_LENGTH_RESET + 16'd1, 8'h01, 1'b0);
   endtask

   // rsp held off while bytes keep coming, then the sender waits it out
   task automatic test_backpressure();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      drain_results();
      long_hold_req = 1'b1;
      send_frame(16'd40, 8'h00, 1'b0);
      send_frame(16'd6, 8'h01, 1'b0);
      drain_results();
   endtask

   task automatic test_random_traffic();
      logic [15:0] value;
      logic [15:0] len;
      logic [7:0]  ftype;
      int unsigned hi;
      int unsigned pick;
      while (bytes_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:       value = 16'($urandom_range(0, 5));
            1:       value = 16'hFFFF;
            2, 3:    value = 16'($urandom_range(64, 512));
            default: value = 16'($urandom_range(6, 48));
         endcase
         set_max_len(value);
         tx_idle = ($urandom_range(0, 3) != 0);
         rx_idle = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(8, 20)) begin
            pick  = $urandom_range(0, 19);
            ftype = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
            if (pick == 0) begin
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end else if (pick == 1) begin
               send_byte(SYNC_FIRST);
               send_byte(($urandom_range(0, 1) == 0) ? SYNC_FIRST : 8'($urandom));
            end else if (pick == 2) begin
               if (cfg_max_len < MIN_FRAME_LENGTH)
                  len = 16'($urandom);
               else if (cfg_max_len == 16'hFFFF || $urandom_range(0, 1) == 0)
                  len = 16'($urandom_range(0, 5));
               else
                  len = 16'($urandom_range(cfg_max_len + 1, 65535));
               send_frame(len, ftype, 1'b0);
            end else begin
               hi = (cfg_max_len > 40) ? 40 : cfg_max_len;
               if (cfg_max_len > 40 && $urandom_range(0, 24) == 0)
                  hi = (cfg_max_len > 300) ? 300 : cfg_max_len;
               if (hi < MIN_FRAME_LENGTH)
                  len = 16'($urandom_range(0, 65535));
               else
                  len = 16'($urandom_range(MIN_FRAME_LENGTH, hi));
               send_frame(len, ftype, pick < 5);
            end
         end
      end
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_max_length();
      test_backpressure();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      if (parse_results.size() != 0)
         report_mismatch("results never delivered", 0, parse_results.size());
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/slcd_pkg.sv
rtl/slcd_parser.sv
rtl/slcd_out_reg.sv
rtl/sync_length_checksum_deframer.sv
verif/tb.sv
